// ===== src/lzt_pkg.sv =====
package lzt_pkg;

    typedef logic signed [8:0] t_height;
    typedef logic signed [9:0] t_wide;
    typedef logic        [7:0] t_slot;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_UNUSED  = 2'd2;

    localparam t_height HIDDEN = -9'sd1;

endpackage

// ===== src/layer_zorder_table.sv =====
// Display layer table with a z-order stack. A command word is taken when start is high and
// busy is low; its single result word appears on the o_ result ports for exactly one cycle,
// flagged by o_valid, and the receiver cannot stall it, so capture it on that cycle. Allocate
// scans the in-use flags one slot a cycle until a free slot or the last slot. Set-height
// and free read the old height, plan the move, then shift the stack entries that lie between
// old and new height one entry per cycle through the single read port of the stack-order
// memory, and write the slot last. A rejected command (slot not in use) answers in the next
// cycle; an unused opcode is dropped with no result. No clearing pass is needed after reset.
module layer_zorder_table
    import lzt_pkg::*;
#(
    parameter int LAYERS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  t_slot      i_layer_id,
    input  t_height    i_new_height,
    output logic       o_valid,
    output logic [1:0] o_status,
    output t_slot      o_result_layer,
    output t_height    o_result_height,
    output t_height    o_top_height
);

    // only slots with an 8-bit id can ever be addressed
    localparam int ID_LIMIT = (LAYERS < 256) ? LAYERS : 256;
    localparam int IDX_W    = $clog2(ID_LIMIT);
    localparam logic [8:0]       ID_LIM9  = 9'(ID_LIMIT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ID_LIMIT - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_PLAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;

    // layer height per slot and slot per stack position
    t_height height_mem [ID_LIMIT];
    t_slot   order_mem  [ID_LIMIT];

    logic [2:0]          r_state, n_state;
    logic [ID_LIMIT-1:0] r_in_use, n_in_use;
    t_height             r_top, n_top;
    logic [IDX_W-1:0]    r_scan, n_scan;
    t_slot               r_slot, n_slot;
    logic                r_free, n_free;
    t_height             r_req_in, n_req_in;
    t_wide               r_old, n_old;
    t_wide               r_req, n_req;
    t_wide               r_src, n_src;
    logic                r_up, n_up;
    logic [8:0]          r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pdst, n_pdst;

    logic                r_valid, n_valid;
    logic [1:0]          r_status, n_status;
    t_slot               r_layer, n_layer;
    t_height             r_height, n_height;
    t_height             r_otop, n_otop;

    // memory ports
    logic                h_we;
    logic [IDX_W-1:0]    h_waddr;
    t_height             h_wdata;
    logic [IDX_W-1:0]    h_raddr;
    t_height             r_h_rdata;
    logic                ord_we;
    logic [IDX_W-1:0]    ord_waddr;
    t_slot               ord_wdata;
    logic [IDX_W-1:0]    ord_raddr;
    t_slot               r_ord_rdata;

    // request decode and clamp helpers
    logic                id_ok;
    t_wide               top_w;
    t_wide               limit;
    t_wide               clamped;
    t_wide               step_dst;

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_result_layer  = r_layer;
    assign o_result_height = r_height;
    assign o_top_height    = r_otop;

    assign id_ok     = ({1'b0, i_layer_id} < ID_LIM9);
    assign top_w     = t_wide'(r_top);
    assign h_raddr   = i_layer_id[IDX_W-1:0];
    assign ord_raddr = r_src[IDX_W-1:0];
    assign step_dst  = r_up ? (r_src + 10'sd1) : (r_src - 10'sd1);

    // request limit: top for a visible layer, one above top for a hidden one
    always_comb begin
        limit   = (r_old >= 10'sd0) ? top_w : (top_w + 10'sd1);
        clamped = t_wide'(r_req_in);
        if (clamped > limit) begin
            clamped = limit;
        end
        if (clamped < -10'sd1) begin
            clamped = -10'sd1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_in_use  = r_in_use;
        n_top     = r_top;
        n_scan    = r_scan;
        n_slot    = r_slot;
        n_free    = r_free;
        n_req_in  = r_req_in;
        n_old     = r_old;
        n_req     = r_req;
        n_src     = r_src;
        n_up      = r_up;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_pdst    = r_pdst;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_layer   = r_layer;
        n_height  = r_height;
        n_otop    = r_otop;
        h_we      = 1'b0;
        h_waddr   = r_slot[IDX_W-1:0];
        h_wdata   = HIDDEN;
        ord_we    = 1'b0;
        ord_waddr = r_pdst;
        ord_wdata = r_ord_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_slot   = i_layer_id;
                    n_free   = (i_op == OP_FREE);
                    n_req_in = (i_op == OP_FREE) ? HIDDEN : i_new_height;
                    if (i_op == OP_ALLOC) begin
                        n_scan  = '0;
                        n_state = S_ALLOC;
                    end else if (i_op == OP_SET || i_op == OP_FREE) begin
                        if (!id_ok || !r_in_use[i_layer_id[IDX_W-1:0]]) begin
                            // reject at once, nothing changes
                            n_valid  = 1'b1;
                            n_status = ST_UNUSED;
                            n_layer  = i_layer_id;
                            n_height = HIDDEN;
                            n_otop   = r_top;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_ALLOC: begin
                if (!r_in_use[r_scan]) begin
                    n_in_use[r_scan] = 1'b1;
                    h_we     = 1'b1;
                    h_waddr  = r_scan;
                    h_wdata  = HIDDEN;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_layer  = 8'(r_scan);
                    n_height = HIDDEN;
                    n_otop   = r_top;
                    n_state  = S_IDLE;
                end else if (r_scan == LAST_IDX) begin
                    n_valid  = 1'b1;
                    n_status = ST_NO_FREE;
                    n_layer  = '0;
                    n_height = HIDDEN;
                    n_otop   = r_top;
                    n_state  = S_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_READ: begin
                n_old   = t_wide'(r_h_rdata);
                n_state = S_PLAN;
            end
            S_PLAN: begin
                n_req   = clamped;
                n_pend  = 1'b0;
                n_cnt   = '0;
                n_state = S_SHIFT;
                if (r_old > clamped) begin
                    if (clamped >= 10'sd0) begin
                        // move down the stack: entries between shift up
                        n_up  = 1'b1;
                        n_src = r_old - 10'sd1;
                        n_cnt = 9'(r_old - clamped);
                    end else begin
                        // hide: entries above close the gap
                        n_up  = 1'b0;
                        n_src = r_old + 10'sd1;
                        n_cnt = 9'(top_w - r_old);
                        n_top = r_top - 9'sd1;
                    end
                end else if (r_old < clamped) begin
                    if (r_old >= 10'sd0) begin
                        n_up  = 1'b0;
                        n_src = r_old + 10'sd1;
                        n_cnt = 9'(clamped - r_old);
                    end else begin
                        // show: entries at and above the slot open a gap
                        n_up  = 1'b1;
                        n_src = top_w;
                        n_cnt = 9'(top_w - clamped + 10'sd1);
                        n_top = r_top + 9'sd1;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    // finish the previous move with the word just read
                    ord_we    = 1'b1;
                    ord_waddr = r_pdst;
                    ord_wdata = r_ord_rdata;
                    h_we      = 1'b1;
                    h_waddr   = r_ord_rdata[IDX_W-1:0];
                    h_wdata   = t_height'({1'b0, 8'(r_pdst)});
                end
                if (r_cnt != 9'd0) begin
                    n_pend = 1'b1;
                    n_pdst = step_dst[IDX_W-1:0];
                    n_src  = r_up ? (r_src - 10'sd1) : (r_src + 10'sd1);
                    n_cnt  = r_cnt - 9'd1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                h_we    = 1'b1;
                h_waddr = r_slot[IDX_W-1:0];
                h_wdata = r_req[8:0];
                if (r_req >= 10'sd0) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_req[IDX_W-1:0];
                    ord_wdata = r_slot;
                end
                if (r_free) begin
                    n_in_use[r_slot[IDX_W-1:0]] = 1'b0;
                end
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_layer  = r_slot;
                n_height = r_req[8:0];
                n_otop   = r_top;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_top    <= HIDDEN;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_top    <= n_top;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_slot   <= n_slot;
        r_free   <= n_free;
        r_req_in <= n_req_in;
        r_old    <= n_old;
        r_req    <= n_req;
        r_src    <= n_src;
        r_up     <= n_up;
        r_cnt    <= n_cnt;
        r_pdst   <= n_pdst;
        r_status <= n_status;
        r_layer  <= n_layer;
        r_height <= n_height;
        r_otop   <= n_otop;
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            height_mem[h_waddr] <= h_wdata;
        end
        r_h_rdata <= height_mem[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        r_ord_rdata <= order_mem[ord_raddr];
    end

`ifndef SYNTHESIS
    a_valid_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while a command is still running");

    a_pend_shift : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SHIFT))
        else $error("stack move pending outside the shift phase");

    a_final_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> ($past(r_state) == S_SHIFT))
        else $error("final write not preceded by the shift phase");

    a_top_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (t_wide'(r_top) >= -10'sd1) && (t_wide'(r_top) < t_wide'(ID_LIMIT)))
        else $error("top height out of range");
`endif

endmodule
